### hdl/stsu_pkg.sv
`timescale 1ns / 1ps

package stsu_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int DLEN_W     = 11;
    localparam int LAYOUT_W   = 2;
    localparam int GAIN_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_LAYOUT = 2'd1,
        CFG_DELAY  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_MATRIX = 1'b0,
        MODE_DELAY  = 1'b1
    } mode_t;

    localparam logic [LAYOUT_W-1:0] LAYOUT_FOUR       = 2'd0;
    localparam logic [LAYOUT_W-1:0] LAYOUT_SIX        = 2'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_EIGHT      = 2'd2;
    localparam logic [LAYOUT_W-1:0] LAYOUT_EIGHT_ALT  = 2'd3;

    localparam logic [DLEN_W-1:0] DELAY_LENGTH_RESET = 11'd480;

    // Q1.15 gains
    localparam logic signed [GAIN_W-1:0] G_080  = 16'sd26214;
    localparam logic signed [GAIN_W-1:0] G_060  = 16'sd19661;
    localparam logic signed [GAIN_W-1:0] G_0707 = 16'sd23167;
    localparam logic signed [GAIN_W-1:0] G_030  = 16'sd9830;
    localparam logic signed [GAIN_W-1:0] G_070  = 16'sd22938;
    localparam logic signed [GAIN_W-1:0] G_020  = 16'sd6554;

    typedef struct packed {
        logic rd;
        logic wr;
        logic step;
    } dly_req_t;

    typedef struct packed {
        mode_t mode;
        logic  six;
        logic  eight;
    } cfg_flags_t;

endpackage

### hdl/stsu_in_if.sv
`timescale 1ns / 1ps

interface stsu_in_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          block_last;

    modport source (
        output valid,
        output left,
        output right,
        output block_last,
        input  ready
    );

    modport sink (
        input  valid,
        input  left,
        input  right,
        input  block_last,
        output ready
    );
endinterface

### hdl/stsu_out_if.sv
`timescale 1ns / 1ps

interface stsu_out_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] front_left;
    logic signed [SAMPLE_BITS-1:0] front_right;
    logic signed [SAMPLE_BITS-1:0] center;
    logic signed [SAMPLE_BITS-1:0] low_frequency;
    logic signed [SAMPLE_BITS-1:0] surround_left;
    logic signed [SAMPLE_BITS-1:0] surround_right;
    logic signed [SAMPLE_BITS-1:0] rear_left;
    logic signed [SAMPLE_BITS-1:0] rear_right;
    logic                          block_last_out;

    modport source (
        output valid,
        output front_left,
        output front_right,
        output center,
        output low_frequency,
        output surround_left,
        output surround_right,
        output rear_left,
        output rear_right,
        output block_last_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  front_left,
        input  front_right,
        input  center,
        input  low_frequency,
        input  surround_left,
        input  surround_right,
        input  rear_left,
        input  rear_right,
        input  block_last_out,
        output ready
    );
endinterface

### hdl/stsu_ram.sv
`timescale 1ns / 1ps

module stsu_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old entry on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/stsu_delay.sv
`timescale 1ns / 1ps

module stsu_delay
    import stsu_pkg::*;
#(
    parameter int DELAY_DEPTH = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dly_req_t                      req,
    input  logic [DLEN_W-1:0]             delay_length,
    input  logic signed [SAMPLE_BITS:0]   sum,
    output logic                          cleared,
    output logic signed [SAMPLE_BITS-1:0] delay_q
);

    localparam int ADDR_W = $clog2(DELAY_DEPTH);
    localparam int LEN_W  = $clog2(DELAY_DEPTH + 1);
    localparam int CMP_W  = (LEN_W > DLEN_W) ? LEN_W : DLEN_W;
    localparam logic [CMP_W-1:0]  DEPTH_C = CMP_W'(DELAY_DEPTH);
    localparam logic [CMP_W-1:0]  ONE_C   = CMP_W'(1);
    localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(DELAY_DEPTH - 1);
    localparam logic signed [SAMPLE_BITS+1:0] ONE_W = (SAMPLE_BITS + 2)'(1);

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              cleared_reg, cleared_next;
    logic [ADDR_W-1:0] wpos_reg, wpos_next;

    logic [CMP_W-1:0]  len;
    logic [CMP_W-1:0]  dl_ext;
    logic [CMP_W-1:0]  pos_c;
    logic [CMP_W-1:0]  pos_inc;
    logic [ADDR_W-1:0] pos;

    logic signed [SAMPLE_BITS+1:0] sum_w;
    logic signed [SAMPLE_BITS+1:0] sum_inc;
    logic signed [SAMPLE_BITS-1:0] store_val;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    always_comb
    begin
        dl_ext = CMP_W'(delay_length);
        if (dl_ext == '0)
        begin
            len = ONE_C;
        end
        else if (dl_ext > DEPTH_C)
        begin
            len = DEPTH_C;
        end
        else
        begin
            len = dl_ext;
        end
        pos_c = CMP_W'(wpos_reg);
        if (pos_c >= len)
        begin
            pos_c = '0;
        end
        pos     = pos_c[ADDR_W-1:0];
        pos_inc = pos_c + ONE_C;
        if (pos_inc >= len)
        begin
            pos_inc = '0;
        end
        wpos_next = req.step ? pos_inc[ADDR_W-1:0] : wpos_reg;
    end

    // stored entry is (l+r)/2 rounded half up
    always_comb
    begin
        sum_w     = (SAMPLE_BITS + 2)'(sum);
        sum_inc   = sum_w + ONE_W;
        store_val = sum_inc[SAMPLE_BITS:1];
    end

    always_comb
    begin
        clr_cnt_next = clr_cnt_reg;
        cleared_next = cleared_reg;
        if (!cleared_reg)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
            if (clr_cnt_reg == LAST_A)
            begin
                cleared_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            cleared_reg <= 1'b0;
            wpos_reg    <= '0;
        end
        else
        begin
            clr_cnt_reg <= clr_cnt_next;
            cleared_reg <= cleared_next;
            wpos_reg    <= wpos_next;
        end
    end

    assign ram_we    = !cleared_reg || req.wr;
    assign ram_waddr = cleared_reg ? pos : clr_cnt_reg;
    assign ram_wdata = cleared_reg ? store_val : '0;

    stsu_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DELAY_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (req.rd),
        .raddr (pos),
        .rdata (ram_rdata)
    );

    assign cleared = cleared_reg;
    assign delay_q = ram_rdata;

endmodule

### hdl/stsu_mix.sv
`timescale 1ns / 1ps

module stsu_mix
    import stsu_pkg::*;
#(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    stsu_in_if.sink                       stereo,
    stsu_out_if.source                    surround,
    input  logic                          cleared,
    input  cfg_flags_t                    flags,
    input  logic signed [SAMPLE_BITS:0]   in_sum,
    input  logic signed [SAMPLE_BITS-1:0] delay_q,
    output logic                          accept
);

    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = SB + 17;
    localparam int ACC_W  = PROD_W + 1;
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0] SMAX_W = ACC_W'({1'b0, {(SB-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] SMIN_W = ~SMAX_W;
    localparam logic signed [SB:0]      ONE_S  = (SB + 1)'(1);

    function automatic logic signed [SB-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        t = (acc + RND) >>> 15;
        if (t > SMAX_W)
        begin
            t = SMAX_W;
        end
        else if (t < SMIN_W)
        begin
            t = SMIN_W;
        end
        return t[SB-1:0];
    endfunction

    // x * 0.5 in Q1.15, rounded half up; never saturates
    function automatic logic signed [SB-1:0] half_up(input logic signed [SB-1:0] x);
        logic signed [SB:0] t;
        t = (SB + 1)'(x) + ONE_S;
        return t[SB:1];
    endfunction

    logic en1, en2, en_o;
    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic vo_reg, vo_next;

    logic signed [SB-1:0] l1_reg, r1_reg;
    logic signed [SB:0]   s1_reg;
    cfg_flags_t           f1_reg;
    logic                 last1_reg;

    logic signed [PROD_W-1:0] p_fl_l_reg, p_fl_r_reg, p_fr_l_reg, p_fr_r_reg;
    logic signed [PROD_W-1:0] p_c_reg, p_lfe_reg, p_sl_reg, p_sr_reg;
    logic signed [SB-1:0]     l2_reg, r2_reg, d2_reg;
    cfg_flags_t               f2_reg;
    logic                     last2_reg;
    logic signed [GAIN_W-1:0] g_lfe;

    logic signed [SB-1:0] fl_reg, fr_reg, c_reg, lfe_reg, sl_reg, sr_reg, rl_reg, rr_reg;
    logic signed [SB-1:0] fl_next, fr_next, c_next, lfe_next;
    logic signed [SB-1:0] sl_next, sr_next, rl_next, rr_next;
    logic                 last_o_reg;

    assign en_o   = !vo_reg || surround.ready;
    assign en2    = !v2_reg || en_o;
    assign en1    = !v1_reg || en2;
    assign stereo.ready = en1 && cleared;
    assign accept = stereo.valid && en1 && cleared;

    assign v1_next = en1 ? accept : v1_reg;
    assign v2_next = en2 ? v1_reg : v2_reg;
    assign vo_next = en_o ? v2_reg : vo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            vo_reg <= vo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            l1_reg    <= stereo.left;
            r1_reg    <= stereo.right;
            s1_reg    <= in_sum;
            f1_reg    <= flags;
            last1_reg <= stereo.block_last;
        end
    end

    assign g_lfe = (f1_reg.mode == MODE_DELAY) ? G_020 : G_030;

    always_ff @(posedge clk)
    begin
        if (v1_reg && en2)
        begin
            p_fl_l_reg <= PROD_W'(l1_reg) * PROD_W'(G_080);
            p_fl_r_reg <= PROD_W'(r1_reg) * PROD_W'(G_060);
            p_fr_l_reg <= PROD_W'(l1_reg) * PROD_W'(G_060);
            p_fr_r_reg <= PROD_W'(r1_reg) * PROD_W'(G_080);
            p_c_reg    <= PROD_W'(s1_reg) * PROD_W'(G_0707);
            p_lfe_reg  <= PROD_W'(s1_reg) * PROD_W'(g_lfe);
            p_sl_reg   <= PROD_W'(l1_reg) * PROD_W'(G_070);
            p_sr_reg   <= PROD_W'(r1_reg) * PROD_W'(G_070);
            l2_reg     <= l1_reg;
            r2_reg     <= r1_reg;
            d2_reg     <= delay_q;
            f2_reg     <= f1_reg;
            last2_reg  <= last1_reg;
        end
    end

    always_comb
    begin
        c_next   = round_sat(ACC_W'(p_c_reg));
        lfe_next = round_sat(ACC_W'(p_lfe_reg));
        sl_next  = '0;
        sr_next  = '0;
        rl_next  = '0;
        rr_next  = '0;
        if (f2_reg.mode == MODE_DELAY)
        begin
            fl_next = l2_reg;
            fr_next = r2_reg;
            if (f2_reg.six)
            begin
                sl_next = half_up(d2_reg);
                sr_next = half_up(d2_reg);
            end
        end
        else
        begin
            fl_next = round_sat(ACC_W'(p_fl_l_reg) + ACC_W'(p_fl_r_reg));
            fr_next = round_sat(ACC_W'(p_fr_l_reg) + ACC_W'(p_fr_r_reg));
            if (f2_reg.six)
            begin
                sl_next = round_sat(ACC_W'(p_sl_reg));
                sr_next = round_sat(ACC_W'(p_sr_reg));
            end
            if (f2_reg.eight)
            begin
                rl_next = half_up(l2_reg);
                rr_next = half_up(r2_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v2_reg && en_o)
        begin
            fl_reg     <= fl_next;
            fr_reg     <= fr_next;
            c_reg      <= c_next;
            lfe_reg    <= lfe_next;
            sl_reg     <= sl_next;
            sr_reg     <= sr_next;
            rl_reg     <= rl_next;
            rr_reg     <= rr_next;
            last_o_reg <= last2_reg;
        end
    end

    assign surround.valid          = vo_reg;
    assign surround.front_left     = fl_reg;
    assign surround.front_right    = fr_reg;
    assign surround.center         = c_reg;
    assign surround.low_frequency  = lfe_reg;
    assign surround.surround_left  = sl_reg;
    assign surround.surround_right = sr_reg;
    assign surround.rear_left      = rl_reg;
    assign surround.rear_right     = rr_reg;
    assign surround.block_last_out = last_o_reg;

endmodule

### hdl/stereo_to_surround_upmixer_core.sv
`timescale 1ns / 1ps
// channel    dir   handshake      payload
// stereo     in    valid/ready    left, right, block_last
// surround   out   valid/ready    eight channels, block_last_out
// cfg        in    cfg_we         cfg_index, cfg_data (mode, channel_layout, delay_length)
//
// One item per cycle while not stalled; items pass input, product and output registers.
// The delay store is read once per item in the accept cycle and written then in delay
// mode with six or more channels (one RAM, read before write): one item a cycle.
// After reset a clearing pass zeroes every store entry; stereo.ready is low until it ends.
// Each stage holds while stalled and bubbles are filled, so input is taken
// while a result waits in the output register.

module stereo_to_surround_upmixer_core
    import stsu_pkg::*;
#(
    parameter int DELAY_DEPTH = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    stsu_in_if.sink               stereo,
    stsu_out_if.source            surround
);

    mode_t               mode_reg;
    logic [LAYOUT_W-1:0] layout_reg;
    logic [DLEN_W-1:0]   delay_length_reg;

    cfg_flags_t                  flags;
    dly_req_t                    req;
    logic                        accept;
    logic                        cleared;
    logic signed [SAMPLE_BITS:0] in_sum;
    logic signed [SAMPLE_BITS-1:0] delay_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_MATRIX;
            layout_reg       <= LAYOUT_SIX;
            delay_length_reg <= DELAY_LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MODE:   mode_reg         <= mode_t'(cfg_data[0]);
                CFG_LAYOUT: layout_reg       <= cfg_data[LAYOUT_W-1:0];
                CFG_DELAY:  delay_length_reg <= cfg_data[DLEN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        flags.mode  = mode_reg;
        flags.six   = (layout_reg != LAYOUT_FOUR);
        flags.eight = layout_reg inside {LAYOUT_EIGHT, LAYOUT_EIGHT_ALT};
    end

    assign in_sum = (SAMPLE_BITS + 1)'(stereo.left) + (SAMPLE_BITS + 1)'(stereo.right);

    always_comb
    begin
        req.rd   = accept;
        req.step = accept && (mode_reg == MODE_DELAY);
        req.wr   = accept && (mode_reg == MODE_DELAY) && flags.six;
    end

    stsu_delay #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_delay (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .delay_length (delay_length_reg),
        .sum          (in_sum),
        .cleared      (cleared),
        .delay_q      (delay_q)
    );

    stsu_mix #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mix (
        .clk      (clk),
        .rst_n    (rst_n),
        .stereo   (stereo),
        .surround (surround),
        .cleared  (cleared),
        .flags    (flags),
        .in_sum   (in_sum),
        .delay_q  (delay_q),
        .accept   (accept)
    );

endmodule
